// File: sv/cfr_pkg.sv
// Shared constants for the copy-on-write frame share counter.
`default_nettype none

package cfr_pkg;

  // Share count storage
  localparam int unsigned COUNT_W       = 8;
  localparam int unsigned FRAMES_DEF    = 4096;
  localparam int unsigned MAX_SHARE_DEF = 255;

  // Frame number extraction from an address or PTE
  localparam logic [63:0] FRAME_ADDR_MASK = 64'h000F_FFFF_FFFF_F000;
  localparam int unsigned FRAME_SHIFT     = 12;
  localparam int unsigned PFN_W           = 40;

  // Configuration registers
  localparam int unsigned TE_W      = 13;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned CFG_DAT_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_ENTRIES = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COW_MASK      = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_MASK    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OWNED_MASK    = 4'd3;

  localparam logic [TE_W-1:0] TE_RST    = 13'd4096;
  localparam logic [63:0]     COW_RST   = 64'h200;
  localparam logic [63:0]     WRITE_RST = 64'h2;
  localparam logic [63:0]     OWNED_RST = 64'h400;

endpackage

`default_nettype wire

// File: sv/cow_frame_refcount_fault_resolver.sv
// Top level of the copy-on-write frame share counter and write-fault resolver.
//
// Input channel (in_valid_i / in_ready_o) carries one request per beat: add
// owner, drop owner, resolve write fault, or a no-op (func 3). Output channel (out_valid_o /
// out_ready_i) returns exactly one result beat per request, in order.
// Configuration channel (cfg_valid_i / cfg_ready_o) writes the frame count
// and the three PTE flag masks; it is always ready. The user must write it
// only while idle; the block itself does not enforce this.
// Each request is a read-modify-write of one share count entry: the read is
// issued on the accepting edge, and the count is updated and the result is
// registered once the output register is free. A new request is taken only
// after the previous one has written its entry back; the registered read of
// the count memory and the read-then-write of a single entry set this.
// The result sits in an output register; the next request is taken while it
// waits, and its own completion holds until the output register is free.
//
// After reset the count memory is zeroed by a sweep, one entry per cycle,
// during which in_ready_o stays low. Configuration beats are taken during
// the sweep. Registers return to 4096, 0x200, 0x2, 0x400.
`default_nettype none

module cow_frame_refcount_fault_resolver
  import cfr_pkg::*;
#(
  parameter int unsigned FRAMES    = FRAMES_DEF,
  parameter int unsigned MAX_SHARE = MAX_SHARE_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // configuration
  input  wire logic                 cfg_valid_i,
  output      logic                 cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_DAT_W-1:0] cfg_data_i,
  // requests
  input  wire logic                 in_valid_i,
  output      logic                 in_ready_o,
  input  wire logic [1:0]           func_i,
  input  wire logic [63:0]          phys_addr_i,
  input  wire logic                 pte_found_i,
  input  wire logic [63:0]          pte_value_i,
  input  wire logic [63:0]          spare_frame_i,
  input  wire logic                 spare_valid_i,
  // results
  output      logic                 out_valid_o,
  input  wire logic                 out_ready_i,
  output      logic                 ok_o,
  output      logic [63:0]          new_pte_o,
  output      logic                 copy_needed_o,
  output      logic                 flush_needed_o
);

  localparam int unsigned IdxW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam logic [COUNT_W-1:0] MaxCount = COUNT_W'(MAX_SHARE);

  typedef enum logic [1:0] {
    FUNC_ADD   = 2'd0,
    FUNC_DROP  = 2'd1,
    FUNC_FAULT = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  // ---------------------------------------------------------------- config
  logic [TE_W-1:0] te_q;
  logic [63:0]     cow_q, write_q, owned_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      te_q    <= TE_RST;
      cow_q   <= COW_RST;
      write_q <= WRITE_RST;
      owned_q <= OWNED_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_TABLE_ENTRIES: te_q    <= cfg_data_i[TE_W-1:0];
        CFG_COW_MASK:      cow_q   <= cfg_data_i;
        CFG_WRITE_MASK:    write_q <= cfg_data_i;
        CFG_OWNED_MASK:    owned_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- accept
  state_e state_q;
  logic   busy;
  logic   in_fire;
  logic   exec_fire;

  assign in_ready_o = (state_q == ST_IDLE) && !busy;
  assign in_fire    = in_valid_i && in_ready_o;

  // fault requests index by the PTE's frame, others by phys_addr
  logic [63:0]      sel_addr;
  logic [PFN_W-1:0] pfn;
  logic             in_range;

  always_comb begin
    sel_addr = (func_i == FUNC_FAULT) ? pte_value_i : phys_addr_i;
    pfn      = PFN_W'((sel_addr & FRAME_ADDR_MASK) >> FRAME_SHIFT);
    in_range = (pfn < PFN_W'(te_q)) && (pfn < PFN_W'(FRAMES));
  end

  func_e         func_q;
  logic          range_q;
  logic          found_q, spare_ok_q;
  logic [63:0]   pte_q, spare_q;
  logic [IdxW-1:0] idx_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      func_q     <= func_e'(func_i);
      range_q    <= in_range;
      found_q    <= pte_found_i;
      spare_ok_q <= spare_valid_i;
      pte_q      <= pte_value_i;
      spare_q    <= spare_frame_i;
      idx_q      <= pfn[IdxW-1:0];
    end
  end

  // ---------------------------------------------------------------- table
  logic [COUNT_W-1:0] cnt;
  logic               wr_en;
  logic [COUNT_W-1:0] wr_data;

  cfr_share_table #(
    .FRAMES (FRAMES)
  ) u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .busy_o    (busy),
    .rd_en_i   (in_fire),
    .rd_addr_i (pfn[IdxW-1:0]),
    .rd_data_o (cnt),
    .wr_en_i   (wr_en),
    .wr_addr_i (idx_q),
    .wr_data_i (wr_data)
  );

  // ---------------------------------------------------------------- modify
  logic        r_ok, r_copy, r_flush;
  logic [63:0] r_pte;
  logic        upd;
  logic        cow_hit;
  logic        shared;

  always_comb begin
    r_ok    = 1'b0;
    r_copy  = 1'b0;
    r_flush = 1'b0;
    r_pte   = '0;
    upd     = 1'b0;
    wr_data = cnt;
    cow_hit = (te_q != '0) && found_q && ((pte_q & cow_q) != '0);
    shared  = range_q && (cnt != '0);
    case (func_q)
      FUNC_ADD: begin
        if (range_q && (cnt < MaxCount)) begin
          r_ok    = 1'b1;
          upd     = 1'b1;
          wr_data = cnt + 1'b1;
        end
      end
      FUNC_DROP: begin
        if (range_q && (cnt != '0)) begin
          upd     = 1'b1;
          wr_data = cnt - 1'b1;
        end else begin
          r_ok = 1'b1;
        end
      end
      FUNC_FAULT: begin
        if (cow_hit) begin
          if (!shared) begin
            // sole owner: make writable in place
            r_pte   = (pte_q & ~cow_q) | write_q;
            r_ok    = 1'b1;
            r_flush = 1'b1;
          end else if (spare_ok_q) begin
            // shared: remap to the spare frame, give up one share
            r_pte   = (spare_q & FRAME_ADDR_MASK)
                    | (pte_q & ~FRAME_ADDR_MASK & ~cow_q)
                    | write_q | owned_q;
            r_ok    = 1'b1;
            r_copy  = 1'b1;
            r_flush = 1'b1;
            upd     = 1'b1;
            wr_data = cnt - 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  assign exec_fire = (state_q == ST_EXEC) && (!out_valid_o || out_ready_i);
  assign wr_en     = exec_fire && upd;

  // ---------------------------------------------------------------- control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      out_valid_o    <= 1'b0;
      ok_o           <= 1'b0;
      new_pte_o      <= '0;
      copy_needed_o  <= 1'b0;
      flush_needed_o <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (exec_fire) begin
            state_q        <= ST_IDLE;
            ok_o           <= r_ok;
            new_pte_o      <= r_pte;
            copy_needed_o  <= r_copy;
            flush_needed_o <= r_flush;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
      // a new result replaces the one leaving in the same cycle
      if (exec_fire) begin
        out_valid_o <= 1'b1;
      end else if (out_valid_o && out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/cfr_share_table.sv
// Share count memory with a zeroing sweep after reset.
`default_nettype none

module cfr_share_table
  import cfr_pkg::*;
#(
  parameter int unsigned FRAMES = FRAMES_DEF
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  output      logic                                   busy_o,
  input  wire logic                                   rd_en_i,
  input  wire logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] rd_addr_i,
  output      logic [COUNT_W-1:0]                     rd_data_o,
  input  wire logic                                   wr_en_i,
  input  wire logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] wr_addr_i,
  input  wire logic [COUNT_W-1:0]                     wr_data_i
);

  localparam int unsigned IdxW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(FRAMES - 1);

  logic [COUNT_W-1:0] mem [FRAMES];
  logic [COUNT_W-1:0] rd_data_q;
  logic               clr_q, clr_d;
  logic [IdxW-1:0]    clr_idx_q, clr_idx_d;

  always_comb begin
    clr_d     = clr_q;
    clr_idx_d = clr_idx_q;
    if (clr_q) begin
      clr_idx_d = clr_idx_q + 1'b1;
      if (clr_idx_q == LastIdx) begin
        clr_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_idx_q <= '0;
    end else begin
      clr_q     <= clr_d;
      clr_idx_q <= clr_idx_d;
    end
  end

  // single write port: the sweep owns it until done
  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      mem[clr_idx_q] <= '0;
    end else if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign busy_o    = clr_q;
  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire
